/* rtl/core/sddf_pkg.sv */
`timescale 1ns / 1ps
package sddf_pkg;

	localparam int DIGITS         = 8;
	localparam int POINT_POSITION = 3;

	localparam int VALUE_W    = 28;
	localparam int MAG_W      = 28;
	localparam int COUNT_W    = 4;
	localparam int ADDR_W     = 4;
	localparam int CODE_W     = 8;
	localparam int NIBBLE_W   = 4;
	localparam int BCD_DIGITS = 9;
	localparam int BCD_W      = BCD_DIGITS * NIBBLE_W;
	localparam int POS_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	localparam int DABBLE_STAGES   = 4;
	localparam int STEPS_PER_STAGE = MAG_W / DABBLE_STAGES;

	localparam logic [CODE_W-1:0] CODE_MINUS = 8'h0A;
	localparam logic [CODE_W-1:0] CODE_BLANK = 8'h0F;
	localparam logic [CODE_W-1:0] POINT_BIT  = 8'h80;

	localparam logic [MAG_W-1:0] RANGE_HIGH    = MAG_W'(99999999);
	localparam logic [MAG_W-1:0] RANGE_LOW_MAG = MAG_W'(9999999);

	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(DIGITS);

	typedef struct packed {
		logic               neg;
		logic [COUNT_W-1:0] count;
		logic               point;
		logic               err;
	} side_t;

	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [MAG_W-1:0] bin;
		side_t            side;
	} dd_t;

endpackage

/* rtl/core/sddf_in_if.sv */
`timescale 1ns / 1ps
interface sddf_in_if import sddf_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic        [COUNT_W-1:0] digit_count;
	logic                      point_on;

	modport source (output valid, value, digit_count, point_on, input ready);
	modport sink   (input valid, value, digit_count, point_on, output ready);
endinterface

/* rtl/core/sddf_out_if.sv */
`timescale 1ns / 1ps
interface sddf_out_if import sddf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] digit_address;
	logic [CODE_W-1:0] digit_code;
	logic              range_error;
	logic              last_write;

	modport source (output valid, digit_address, digit_code, range_error, last_write,
		input ready);
	modport sink   (input valid, digit_address, digit_code, range_error, last_write,
		output ready);
endinterface

/* rtl/core/sddf_prep.sv */
`timescale 1ns / 1ps
module sddf_prep import sddf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	sddf_in_if.sink din,
	output logic  out_valid,
	input  logic  out_ready,
	output dd_t   out_data
);

	logic             vld_s1;
	dd_t              dd_s1;
	logic [MAG_W-1:0] raw;
	logic [MAG_W-1:0] mag;
	logic             neg;
	dd_t              prep;

	assign din.ready = !vld_s1 || out_ready;

	always_comb begin
		raw = MAG_W'(din.value);
		neg = raw[MAG_W-1];
		mag = neg ? MAG_W'(~raw + MAG_W'(1)) : raw;
		prep.bcd = '0;
		prep.bin = mag;
		prep.side.neg = neg;
		prep.side.count = (din.digit_count > COUNT_MAX) ? COUNT_MAX : din.digit_count;
		prep.side.point = din.point_on;
		// range test runs on the full value, not on any remainder
		prep.side.err = neg ? (mag > RANGE_LOW_MAG) : (raw > RANGE_HIGH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (din.ready) begin
			vld_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			dd_s1 <= prep;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = dd_s1;

endmodule

/* rtl/core/sddf_dabble.sv */
`timescale 1ns / 1ps
module sddf_dabble import sddf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  dd_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output dd_t  out_data
);

	// one slice of shift-and-add-3 conversion, STEPS_PER_STAGE bits deep
	function automatic dd_t dabble_slice(dd_t d);
		logic [BCD_W-1:0] b;
		logic [MAG_W-1:0] m;
		dd_t              r;
		b = d.bcd;
		m = d.bin;
		for (int s = 0; s < STEPS_PER_STAGE; s++) begin
			for (int k = 0; k < BCD_DIGITS; k++) begin
				if (b[k*NIBBLE_W +: NIBBLE_W] >= NIBBLE_W'(5)) begin
					b[k*NIBBLE_W +: NIBBLE_W] = b[k*NIBBLE_W +: NIBBLE_W] + NIBBLE_W'(3);
				end
			end
			{b, m} = {b[BCD_W-2:0], m, 1'b0};
		end
		r = d;
		r.bcd = b;
		r.bin = m;
		return r;
	endfunction

	logic vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	dd_t  dd_s2, dd_s3, dd_s4, dd_s5;

	assign rdy_s5   = !vld_s5 || out_ready;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s2) vld_s2 <= in_valid;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) dd_s2 <= dabble_slice(in_data);
		if (rdy_s3 && vld_s2)   dd_s3 <= dabble_slice(dd_s2);
		if (rdy_s4 && vld_s3)   dd_s4 <= dabble_slice(dd_s3);
		if (rdy_s5 && vld_s4)   dd_s5 <= dabble_slice(dd_s4);
	end

	assign out_valid = vld_s5;
	assign out_data  = dd_s5;

endmodule

/* rtl/core/sddf_serial.sv */
`timescale 1ns / 1ps
module sddf_serial import sddf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  dd_t  in_data,
	sddf_out_if.source dout
);

	dd_t               item_q;
	logic              busy_q;
	logic [POS_W-1:0]  pos_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [CODE_W-1:0] out_code_q;
	logic              out_err_q;
	logic              out_last_q;

	logic              load;
	logic              last;
	logic              take;
	logic [ADDR_W-1:0] addr;
	logic [CODE_W-1:0] code;

	assign load     = busy_q && (!out_valid_q || dout.ready);
	assign last     = (pos_q == POS_W'(DIGITS - 1));
	assign in_ready = !busy_q || (load && last);
	assign take     = in_valid && in_ready;
	assign addr     = ADDR_W'(pos_q) + ADDR_W'(1);

	always_comb begin
		if (addr > item_q.side.count) begin
			code = CODE_BLANK;
		end else if (item_q.side.neg && addr == item_q.side.count) begin
			code = CODE_MINUS;
		end else begin
			code = CODE_W'(item_q.bcd[pos_q*NIBBLE_W +: NIBBLE_W]);
			if (item_q.side.point && addr == ADDR_W'(POINT_POSITION)) begin
				code = code | POINT_BIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (load) begin
				pos_q <= pos_q + POS_W'(1);
				if (last) busy_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) item_q <= in_data;
		if (load) begin
			out_addr_q <= addr;
			out_code_q <= code;
			out_err_q  <= item_q.side.err;
			out_last_q <= last;
		end
	end

	assign dout.valid         = out_valid_q;
	assign dout.digit_address = out_addr_q;
	assign dout.digit_code    = out_code_q;
	assign dout.range_error   = out_err_q;
	assign dout.last_write    = out_last_q;

endmodule

/* rtl/core/signed_decimal_digit_formatter.sv */
`timescale 1ns / 1ps
// Signed decimal digit formatter for an eight-digit code-B display.
// din carries value (28-bit signed), digit_count and point_on; a transaction
// happens when valid and ready are both high. dout carries one digit-register
// write per transaction: digit_address 1 (least significant) to 8, digit_code,
// range_error (same on all eight writes) and last_write on the eighth.
// Each input transaction yields eight writes in ascending address order.
// The first write is presented after one sign/magnitude stage, four
// binary-to-BCD stages of seven bits each, and the item and output
// registers of the serializer; the rest follow one per cycle while ready
// is high. The serializer takes the next item as it loads the last write
// of the current one; the sign/magnitude and conversion stages take a new
// item every cycle unless stalled, and queue up to five while it works.
// Reset clears all valid bits and the serializer; no item is in flight after.
// When the receiver holds ready low, the current write holds on dout and
// the stages behind it fill and then deassert din.ready; nothing is dropped.
module signed_decimal_digit_formatter import sddf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	sddf_in_if.sink    din,
	sddf_out_if.source dout
);

	logic p_valid, p_ready;
	dd_t  p_data;
	logic c_valid, c_ready;
	dd_t  c_data;

	sddf_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.out_valid (p_valid),
		.out_ready (p_ready),
		.out_data  (p_data)
	);

	sddf_dabble u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p_valid),
		.in_ready  (p_ready),
		.in_data   (p_data),
		.out_valid (c_valid),
		.out_ready (c_ready),
		.out_data  (c_data)
	);

	sddf_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (c_valid),
		.in_ready (c_ready),
		.in_data  (c_data),
		.dout     (dout)
	);

endmodule
